/* src/rigid_body_euler_step_assert.svh */
// Assertion macros shared by the rigid body step RTL.
`ifndef RIGID_BODY_EULER_STEP_ASSERT_SVH
`define RIGID_BODY_EULER_STEP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RBES_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RBES_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/rbes_pkg.sv */
// Types, constants and arithmetic helpers of the rigid body step block.
package rbes_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int STEP_W    = 16;
  localparam int STEP_FRAC = 16;
  localparam int MASS_W    = 31;
  localparam int FRIC_W    = 17;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam int MUL_K_W  = (FRAC_BITS > FRIC_W) ? FRAC_BITS : FRIC_W;
  localparam int PROD_W   = DATA_W + MUL_K_W;
  localparam int NUM_W    = DATA_W + FRAC_BITS;
  localparam int ONE_W    = DATA_W + 1;
  localparam int SQ_W     = 2 * FRAC_BITS;
  localparam int SUM_W    = SQ_W + 2;

  localparam int DIV_RADIX_BITS = 2;
  localparam int DIV_STEPS      = DATA_W / DIV_RADIX_BITS;
  localparam int DIV_CNT_W      = $clog2(DIV_STEPS);

  localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [PROD_W-1:0] SAT_MAX_P = PROD_W'(DATA_MAX);
  localparam logic signed [PROD_W-1:0] SAT_MIN_P = PROD_W'(DATA_MIN);
  localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (STEP_FRAC - 1);

  localparam logic [ONE_W-1:0] ONE_ABS = ONE_W'(1) << FRAC_BITS;

  localparam longint GRAVITY_FIX = ((longint'(49) << FRAC_BITS) + 2) / 5;
  localparam logic signed [DATA_W-1:0] NEG_GRAVITY = DATA_W'(-GRAVITY_FIX);

  localparam longint SNAP_LIMIT_L = ((longint'(1) << (2 * FRAC_BITS)) + 999) / 1000;
  localparam logic [SUM_W-1:0] SNAP_LIMIT = SUM_W'(SNAP_LIMIT_L);

  localparam logic [STEP_W-1:0] RST_STEP_TIME = STEP_W'(1092);
  localparam logic [MASS_W-1:0] RST_BODY_MASS = MASS_W'(1) << FRAC_BITS;
  localparam logic              RST_GRAVITY   = 1'b1;
  localparam logic [FRIC_W-1:0] RST_FRICTION  = FRIC_W'(63570);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP_TIME  = 3'd0,
    CFG_BODY_MASS  = 3'd1,
    CFG_GRAVITY_ON = 3'd2,
    CFG_FRICTION   = 3'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    LANE_IDLE,
    LANE_LOAD,
    LANE_DIV,
    LANE_SIGN,
    LANE_GRAV,
    LANE_MUL_ACC,
    LANE_MUL_VEL,
    LANE_MUL_FRIC,
    LANE_MUL_SQ,
    LANE_ROUND,
    LANE_ADD_VEL,
    LANE_ADD_POS,
    LANE_FRIC,
    LANE_CLEAR
  } lane_op_e;

  typedef struct packed {
    lane_op_e op;
    logic     sub_grav;
    logic     hit;
  } lane_ctrl_t;

  typedef struct packed {
    logic [STEP_W-1:0] step_time;
    logic [MASS_W-1:0] body_mass;
    logic [FRIC_W-1:0] friction;
  } cfg_t;

  typedef struct packed {
    logic            is_small;
    logic [SQ_W-1:0] sq;
  } lane_stat_t;

  function automatic logic signed [DATA_W-1:0] sat_add(
    input logic signed [DATA_W-1:0] a,
    input logic signed [DATA_W-1:0] b
  );
    logic [DATA_W:0] s;
    s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
    if (s[DATA_W] != s[DATA_W-1]) begin
      return s[DATA_W] ? DATA_MIN : DATA_MAX;
    end
    return s[DATA_W-1:0];
  endfunction

  function automatic logic signed [DATA_W-1:0] round_sat(
    input logic signed [PROD_W-1:0] p
  );
    logic signed [PROD_W-1:0] t;
    t = (p + ROUND_HALF) >>> STEP_FRAC;
    if (t > SAT_MAX_P) begin
      return DATA_MAX;
    end else if (t < SAT_MIN_P) begin
      return DATA_MIN;
    end
    return t[DATA_W-1:0];
  endfunction

  function automatic logic [MASS_W:0] div_step(
    input logic [MASS_W-1:0] rem,
    input logic              bit_in,
    input logic [MASS_W-1:0] mass
  );
    logic [MASS_W:0] t;
    logic [MASS_W:0] diff;
    t    = {rem, bit_in};
    diff = t - {1'b0, mass};
    if (t >= {1'b0, mass}) begin
      return {1'b1, diff[MASS_W-1:0]};
    end
    return {1'b0, t[MASS_W-1:0]};
  endfunction

endpackage

/* src/rbes_lane.sv */
// One axis lane: force divider, shared multiplier and velocity and position update.
module rbes_lane (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  rbes_pkg::lane_ctrl_t                  ctrl_i,
  input  rbes_pkg::cfg_t                        cfg_i,
  input  logic signed [rbes_pkg::DATA_W-1:0]    force_i,
  input  logic signed [rbes_pkg::DATA_W-1:0]    pos_i,
  input  logic signed [rbes_pkg::DATA_W-1:0]    floor_i,
  output rbes_pkg::lane_stat_t                  stat_o,
  output logic signed [rbes_pkg::DATA_W-1:0]    pos_o,
  output logic signed [rbes_pkg::DATA_W-1:0]    vel_o
);

  logic [rbes_pkg::MASS_W-1:0]           rem_q;
  logic [rbes_pkg::DATA_W-1:0]           quo_q;
  logic                                  ovf_q;
  logic                                  neg_q;
  logic                                  zero_q;
  logic signed [rbes_pkg::DATA_W-1:0]    acc_q;
  logic signed [rbes_pkg::PROD_W-1:0]    prod_q;
  logic signed [rbes_pkg::DATA_W-1:0]    term_q;
  logic signed [rbes_pkg::DATA_W-1:0]    pos_q;
  logic signed [rbes_pkg::DATA_W-1:0]    vel_q;
  logic [rbes_pkg::FRAC_BITS-1:0]        mag_q;
  logic                                  small_q;

  logic [rbes_pkg::DATA_W-1:0]           abs_f;
  logic [rbes_pkg::NUM_W-1:0]            num;
  logic [rbes_pkg::MASS_W-1:0]           rem_init;
  logic [rbes_pkg::MASS_W:0]             step1;
  logic [rbes_pkg::MASS_W:0]             step2;
  logic signed [rbes_pkg::DATA_W-1:0]    quo_signed;
  logic signed [rbes_pkg::DATA_W-1:0]    a_sel;
  logic [rbes_pkg::MUL_K_W-1:0]          k_sel;
  logic signed [rbes_pkg::PROD_W:0]      mul_full;
  logic [rbes_pkg::ONE_W-1:0]            v_ext;
  logic [rbes_pkg::ONE_W-1:0]            abs_v;

  always_comb begin
    abs_f    = force_i[rbes_pkg::DATA_W-1] ? -force_i : force_i;
    num      = {abs_f, {rbes_pkg::FRAC_BITS{1'b0}}};
    rem_init = rbes_pkg::MASS_W'(num[rbes_pkg::NUM_W-1:rbes_pkg::DATA_W]);

    step1 = rbes_pkg::div_step(rem_q, quo_q[rbes_pkg::DATA_W-1], cfg_i.body_mass);
    step2 = rbes_pkg::div_step(step1[rbes_pkg::MASS_W-1:0], quo_q[rbes_pkg::DATA_W-2],
                               cfg_i.body_mass);

    if (zero_q) begin
      quo_signed = '0;
    end else if (ovf_q || quo_q[rbes_pkg::DATA_W-1]) begin
      quo_signed = neg_q ? rbes_pkg::DATA_MIN : rbes_pkg::DATA_MAX;
    end else begin
      quo_signed = neg_q ? -quo_q : quo_q;
    end

    case (ctrl_i.op)
      rbes_pkg::LANE_MUL_ACC: begin
        a_sel = acc_q;
        k_sel = rbes_pkg::MUL_K_W'(cfg_i.step_time);
      end
      rbes_pkg::LANE_MUL_VEL: begin
        a_sel = vel_q;
        k_sel = rbes_pkg::MUL_K_W'(cfg_i.step_time);
      end
      rbes_pkg::LANE_MUL_FRIC: begin
        a_sel = vel_q;
        k_sel = rbes_pkg::MUL_K_W'(cfg_i.friction);
      end
      rbes_pkg::LANE_MUL_SQ: begin
        a_sel = $signed(rbes_pkg::DATA_W'(mag_q));
        k_sel = rbes_pkg::MUL_K_W'(mag_q);
      end
      default: begin
        a_sel = '0;
        k_sel = '0;
      end
    endcase
    mul_full = a_sel * $signed({1'b0, k_sel});

    v_ext = {term_q[rbes_pkg::DATA_W-1], term_q};
    abs_v = v_ext[rbes_pkg::DATA_W] ? (~v_ext + 1'b1) : v_ext;
  end

  always_ff @(posedge clk_i) begin
    case (ctrl_i.op)
      rbes_pkg::LANE_LOAD: begin
        rem_q  <= rem_init;
        quo_q  <= num[rbes_pkg::DATA_W-1:0];
        ovf_q  <= (rem_init >= cfg_i.body_mass);
        neg_q  <= force_i[rbes_pkg::DATA_W-1];
        zero_q <= (force_i == '0);
        pos_q  <= pos_i;
      end
      rbes_pkg::LANE_DIV: begin
        rem_q <= step2[rbes_pkg::MASS_W-1:0];
        quo_q <= {quo_q[rbes_pkg::DATA_W-3:0], step1[rbes_pkg::MASS_W],
                  step2[rbes_pkg::MASS_W]};
      end
      rbes_pkg::LANE_SIGN: begin
        acc_q <= quo_signed;
      end
      rbes_pkg::LANE_GRAV: begin
        if (ctrl_i.sub_grav) begin
          acc_q <= rbes_pkg::sat_add(acc_q, rbes_pkg::NEG_GRAVITY);
        end
      end
      rbes_pkg::LANE_MUL_ACC, rbes_pkg::LANE_MUL_VEL,
      rbes_pkg::LANE_MUL_FRIC, rbes_pkg::LANE_MUL_SQ: begin
        prod_q <= mul_full[rbes_pkg::PROD_W-1:0];
      end
      rbes_pkg::LANE_ROUND: begin
        term_q <= rbes_pkg::round_sat(prod_q);
      end
      rbes_pkg::LANE_ADD_VEL: begin
        if (ctrl_i.hit) begin
          pos_q <= floor_i;
        end
      end
      rbes_pkg::LANE_ADD_POS: begin
        pos_q <= rbes_pkg::sat_add(pos_q, term_q);
      end
      rbes_pkg::LANE_FRIC: begin
        mag_q   <= abs_v[rbes_pkg::FRAC_BITS-1:0];
        small_q <= (abs_v < rbes_pkg::ONE_ABS);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vel_q <= '0;
    end else begin
      case (ctrl_i.op)
        rbes_pkg::LANE_ADD_VEL: begin
          vel_q <= ctrl_i.hit ? '0 : rbes_pkg::sat_add(vel_q, term_q);
        end
        rbes_pkg::LANE_FRIC: begin
          vel_q <= term_q;
        end
        rbes_pkg::LANE_CLEAR: begin
          vel_q <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  assign stat_o = '{is_small: small_q, sq: prod_q[rbes_pkg::SQ_W-1:0]};
  assign pos_o  = pos_q;
  assign vel_o  = vel_q;

endmodule

/* src/rbes_merge.sv */
// Merging stage: sums the squared lane speeds and decides the rest snap.
module rbes_merge (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  rbes_pkg::lane_stat_t stat_x_i,
  input  rbes_pkg::lane_stat_t stat_y_i,
  input  rbes_pkg::lane_stat_t stat_z_i,
  output logic                 snap_o
);

  logic [rbes_pkg::SUM_W-1:0] sum;
  logic                       snap_q;

  assign sum = rbes_pkg::SUM_W'(stat_x_i.sq) + rbes_pkg::SUM_W'(stat_y_i.sq)
             + rbes_pkg::SUM_W'(stat_z_i.sq);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snap_q <= 1'b0;
    end else if (en_i) begin
      snap_q <= stat_x_i.is_small && stat_y_i.is_small && stat_z_i.is_small
                && (sum < rbes_pkg::SNAP_LIMIT);
    end
  end

  assign snap_o = snap_q;

endmodule

/* src/rigid_body_euler_step.sv */
// Top level of the rigid body step: sequencer, configuration, lanes and result register.
// An accepted beat runs through the divide and update states to the result register, or
// directly to it when step time is zero. A new beat is taken only when idle; each lane uses
// a two-bit-per-cycle divider and a single multiplier that it shares for all its products.
// Reset clears velocity, the landed flag and the result register, and loads the
// default configuration; there is no clearing pass.
`include "rigid_body_euler_step_assert.svh"

module rigid_body_euler_step (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic signed [rbes_pkg::DATA_W-1:0]     force_x_i,
  input  logic signed [rbes_pkg::DATA_W-1:0]     force_y_i,
  input  logic signed [rbes_pkg::DATA_W-1:0]     force_z_i,
  input  logic signed [rbes_pkg::DATA_W-1:0]     pos_x_i,
  input  logic signed [rbes_pkg::DATA_W-1:0]     pos_y_i,
  input  logic signed [rbes_pkg::DATA_W-1:0]     pos_z_i,
  input  logic signed [rbes_pkg::DATA_W-1:0]     ground_height_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [rbes_pkg::DATA_W-1:0]     new_x_o,
  output logic signed [rbes_pkg::DATA_W-1:0]     new_y_o,
  output logic signed [rbes_pkg::DATA_W-1:0]     new_z_o,
  output logic signed [rbes_pkg::DATA_W-1:0]     vel_out_x_o,
  output logic signed [rbes_pkg::DATA_W-1:0]     vel_out_y_o,
  output logic signed [rbes_pkg::DATA_W-1:0]     vel_out_z_o,
  output logic                                   on_ground_o,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [rbes_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [rbes_pkg::CFG_DATA_W-1:0]        cfg_data_i
);

  typedef enum logic [4:0] {
    S_IDLE,
    S_DIV,
    S_SIGN,
    S_GRAV,
    S_MUL_ACC,
    S_RND_ACC,
    S_VEL,
    S_MUL_VEL,
    S_RND_VEL,
    S_POS,
    S_MUL_FRIC,
    S_RND_FRIC,
    S_FRIC,
    S_MUL_SQ,
    S_MERGE,
    S_SNAP,
    S_DONE
  } state_e;

  state_e                              state_q;
  logic [rbes_pkg::DIV_CNT_W-1:0]      div_cnt_q;
  logic                                landed_q;
  logic                                out_valid_q;
  logic signed [rbes_pkg::DATA_W-1:0]  new_x_q;
  logic signed [rbes_pkg::DATA_W-1:0]  new_y_q;
  logic signed [rbes_pkg::DATA_W-1:0]  new_z_q;
  logic signed [rbes_pkg::DATA_W-1:0]  vel_x_q;
  logic signed [rbes_pkg::DATA_W-1:0]  vel_y_q;
  logic signed [rbes_pkg::DATA_W-1:0]  vel_z_q;
  logic                                ground_q;

  logic [rbes_pkg::STEP_W-1:0]         step_time_q;
  logic [rbes_pkg::MASS_W-1:0]         body_mass_q;
  logic                                gravity_on_q;
  logic [rbes_pkg::FRIC_W-1:0]         friction_q;

  logic                                hit_q;
  logic signed [rbes_pkg::DATA_W-1:0]  gh_q;

  logic                                in_accept;
  logic                                merge_en;
  logic                                snap;
  rbes_pkg::lane_op_e                  lane_op;
  rbes_pkg::lane_ctrl_t                ctrl_x;
  rbes_pkg::lane_ctrl_t                ctrl_y;
  rbes_pkg::lane_ctrl_t                ctrl_z;
  rbes_pkg::cfg_t                      cfg;
  rbes_pkg::lane_stat_t                stat_x;
  rbes_pkg::lane_stat_t                stat_y;
  rbes_pkg::lane_stat_t                stat_z;
  logic signed [rbes_pkg::DATA_W-1:0]  pos_x;
  logic signed [rbes_pkg::DATA_W-1:0]  pos_y;
  logic signed [rbes_pkg::DATA_W-1:0]  pos_z;
  logic signed [rbes_pkg::DATA_W-1:0]  vel_x;
  logic signed [rbes_pkg::DATA_W-1:0]  vel_y;
  logic signed [rbes_pkg::DATA_W-1:0]  vel_z;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_time_q  <= rbes_pkg::RST_STEP_TIME;
      body_mass_q  <= rbes_pkg::RST_BODY_MASS;
      gravity_on_q <= rbes_pkg::RST_GRAVITY;
      friction_q   <= rbes_pkg::RST_FRICTION;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        rbes_pkg::CFG_STEP_TIME:  step_time_q  <= cfg_data_i[rbes_pkg::STEP_W-1:0];
        rbes_pkg::CFG_BODY_MASS:  body_mass_q  <= cfg_data_i[rbes_pkg::MASS_W-1:0];
        rbes_pkg::CFG_GRAVITY_ON: gravity_on_q <= cfg_data_i[0];
        rbes_pkg::CFG_FRICTION:   friction_q   <= cfg_data_i[rbes_pkg::FRIC_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      hit_q <= gravity_on_q && (pos_y_i <= ground_height_i);
      gh_q  <= ground_height_i;
    end
  end

  always_comb begin
    lane_op  = rbes_pkg::LANE_IDLE;
    merge_en = 1'b0;
    case (state_q)
      S_IDLE:     if (in_accept) lane_op = rbes_pkg::LANE_LOAD;
      S_DIV:      lane_op = rbes_pkg::LANE_DIV;
      S_SIGN:     lane_op = rbes_pkg::LANE_SIGN;
      S_GRAV:     lane_op = rbes_pkg::LANE_GRAV;
      S_MUL_ACC:  lane_op = rbes_pkg::LANE_MUL_ACC;
      S_RND_ACC:  lane_op = rbes_pkg::LANE_ROUND;
      S_VEL:      lane_op = rbes_pkg::LANE_ADD_VEL;
      S_MUL_VEL:  lane_op = rbes_pkg::LANE_MUL_VEL;
      S_RND_VEL:  lane_op = rbes_pkg::LANE_ROUND;
      S_POS:      lane_op = rbes_pkg::LANE_ADD_POS;
      S_MUL_FRIC: lane_op = rbes_pkg::LANE_MUL_FRIC;
      S_RND_FRIC: lane_op = rbes_pkg::LANE_ROUND;
      S_FRIC:     lane_op = rbes_pkg::LANE_FRIC;
      S_MUL_SQ:   lane_op = rbes_pkg::LANE_MUL_SQ;
      S_MERGE:    merge_en = 1'b1;
      S_SNAP:     if (snap) lane_op = rbes_pkg::LANE_CLEAR;
      default: begin
      end
    endcase
  end

  assign ctrl_x = '{op: lane_op, sub_grav: 1'b0, hit: 1'b0};
  assign ctrl_y = '{op: lane_op, sub_grav: gravity_on_q, hit: hit_q};
  assign ctrl_z = '{op: lane_op, sub_grav: 1'b0, hit: 1'b0};
  assign cfg    = '{step_time: step_time_q, body_mass: body_mass_q, friction: friction_q};

  rbes_lane u_lane_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl_x),
    .cfg_i   (cfg),
    .force_i (force_x_i),
    .pos_i   (pos_x_i),
    .floor_i ('0),
    .stat_o  (stat_x),
    .pos_o   (pos_x),
    .vel_o   (vel_x)
  );

  rbes_lane u_lane_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl_y),
    .cfg_i   (cfg),
    .force_i (force_y_i),
    .pos_i   (pos_y_i),
    .floor_i (gh_q),
    .stat_o  (stat_y),
    .pos_o   (pos_y),
    .vel_o   (vel_y)
  );

  rbes_lane u_lane_z (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl_z),
    .cfg_i   (cfg),
    .force_i (force_z_i),
    .pos_i   (pos_z_i),
    .floor_i ('0),
    .stat_o  (stat_z),
    .pos_o   (pos_z),
    .vel_o   (vel_z)
  );

  rbes_merge u_merge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (merge_en),
    .stat_x_i (stat_x),
    .stat_y_i (stat_y),
    .stat_z_i (stat_z),
    .snap_o   (snap)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      div_cnt_q   <= '0;
      landed_q    <= 1'b0;
      out_valid_q <= 1'b0;
      new_x_q     <= '0;
      new_y_q     <= '0;
      new_z_q     <= '0;
      vel_x_q     <= '0;
      vel_y_q     <= '0;
      vel_z_q     <= '0;
      ground_q    <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            state_q <= (step_time_q == '0) ? S_DONE : S_DIV;
          end
        end
        S_DIV: begin
          if (div_cnt_q == rbes_pkg::DIV_CNT_W'(rbes_pkg::DIV_STEPS - 1)) begin
            div_cnt_q <= '0;
            state_q   <= S_SIGN;
          end else begin
            div_cnt_q <= div_cnt_q + 1'b1;
          end
        end
        S_SIGN:     state_q <= S_GRAV;
        S_GRAV:     state_q <= S_MUL_ACC;
        S_MUL_ACC:  state_q <= S_RND_ACC;
        S_RND_ACC:  state_q <= S_VEL;
        S_VEL: begin
          if (hit_q) begin
            landed_q <= 1'b1;
          end
          state_q <= S_MUL_VEL;
        end
        S_MUL_VEL:  state_q <= S_RND_VEL;
        S_RND_VEL:  state_q <= S_POS;
        S_POS:      state_q <= S_MUL_FRIC;
        S_MUL_FRIC: state_q <= S_RND_FRIC;
        S_RND_FRIC: state_q <= S_FRIC;
        S_FRIC:     state_q <= S_MUL_SQ;
        S_MUL_SQ:   state_q <= S_MERGE;
        S_MERGE:    state_q <= S_SNAP;
        S_SNAP:     state_q <= S_DONE;
        S_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            new_x_q     <= pos_x;
            new_y_q     <= pos_y;
            new_z_q     <= pos_z;
            vel_x_q     <= vel_x;
            vel_y_q     <= vel_y;
            vel_z_q     <= vel_z;
            ground_q    <= landed_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign new_x_o     = new_x_q;
  assign new_y_o     = new_y_q;
  assign new_z_o     = new_z_q;
  assign vel_out_x_o = vel_x_q;
  assign vel_out_y_o = vel_y_q;
  assign vel_out_z_o = vel_z_q;
  assign on_ground_o = ground_q;

  `RBES_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o, "An accepted input beat did not make the block busy.")
  `RBES_ASSERT_NEXT(a_landed_sticky, clk_i, rst_ni, landed_q, landed_q, "The landed flag dropped without a reset.")
  `RBES_ASSERT_NOW(a_div_cnt_rest, clk_i, rst_ni, state_q != S_DIV, div_cnt_q == '0, "The divider count is nonzero outside the divide phase.")
  `RBES_ASSERT_NEXT(a_snap_clears, clk_i, rst_ni, state_q == S_SNAP && snap, vel_x == '0 && vel_y == '0 && vel_z == '0, "A rest snap left a nonzero velocity.")

endmodule
